// ----- rtl/core/rtcc_pkg.sv -----
package rtcc_pkg;

   // Relay count used when the top level is not told otherwise.
   localparam int RELAYS_DEF = 8;

   // The drive byte carries at most this many relays.
   localparam int DRIVE_BITS = 8;

   // Reset value of the maximum duration register, in seconds.
   localparam logic [15:0] MAX_DUR_RST = 16'd3600;

   typedef enum logic [3:0] {
      MODE_TICK       = 4'd0,
      MODE_ON         = 4'd1,
      MODE_OFF        = 4'd2,
      MODE_TOGGLE     = 4'd3,
      MODE_TIMED_ON   = 4'd4,
      MODE_TIMED_OFF  = 4'd5,
      MODE_CYCLE      = 4'd6,
      MODE_CYCLE_STOP = 4'd7,
      MODE_STATUS     = 4'd8
   } mode_type;

   // Timer and cycle record of one relay, as held in the entry memory.
   typedef struct packed {
      logic        timer_active;
      logic [15:0] timer_length;
      logic [15:0] elapsed;
      logic        cycle_active;
      logic        phase_is_on;
      logic [15:0] on_len;
      logic [15:0] off_len;
   } entry_type;

   // A record together with the relay's output bit.
   typedef struct packed {
      logic      relay_on;
      entry_type entry;
   } relay_type;

   function automatic logic [15:0] clamp_len(logic [15:0] v, logic [15:0] lim);
      return (v > lim) ? lim : v;
   endfunction

   // One second passes for one relay.
   function automatic relay_type tick_step(relay_type cur);
      relay_type   nxt;
      logic [15:0] el;
      logic [15:0] len;
      nxt = cur;
      el  = cur.entry.elapsed;
      if ((cur.entry.timer_active || cur.entry.cycle_active) && (el != 16'hFFFF)) begin
         el = el + 16'd1;
      end
      nxt.entry.elapsed = el;
      if (!cur.entry.cycle_active) begin
         if (cur.entry.timer_active && cur.relay_on && (el >= cur.entry.timer_length)) begin
            nxt.relay_on           = 1'b0;
            nxt.entry.timer_active = 1'b0;
            nxt.entry.timer_length = 16'd0;
         end
      end else begin
         len = cur.entry.phase_is_on ? cur.entry.on_len : cur.entry.off_len;
         nxt.entry.timer_active = 1'b1;
         nxt.entry.timer_length = len;
         if (el >= len) begin
            nxt.entry.phase_is_on  = !cur.entry.phase_is_on;
            nxt.relay_on           = !cur.entry.phase_is_on;
            nxt.entry.elapsed      = 16'd0;
            nxt.entry.timer_length = cur.entry.phase_is_on ? cur.entry.off_len
                                                           : cur.entry.on_len;
         end
      end
      return nxt;
   endfunction

   // Seconds left in the running timer or cycle phase, floored at zero.
   function automatic logic [15:0] remaining(entry_type e);
      logic [15:0] len;
      if (e.cycle_active) begin
         len = e.phase_is_on ? e.on_len : e.off_len;
      end else if (e.timer_active) begin
         len = e.timer_length;
      end else begin
         len = 16'd0;
      end
      return (len > e.elapsed) ? (len - e.elapsed) : 16'd0;
   endfunction

endpackage

// ----- rtl/core/relay_timer_cycle_controller_top.sv -----
// Channel   Direction  Ports                                    Transfer
// request   in         start, busy, req_mode, req_relay_index,  start high while busy low
//                      req_duration, req_off_seconds
// response  out        rsp_valid, rsp_ok, rsp_relay_is_on,      one cycle per beat, no stall
//                      rsp_timer_running, rsp_remaining_seconds,
//                      rsp_drive_n
// csr       in         csr_wr_en, csr_wr_data                   written when csr_wr_en is high
//
// A relay command reads its entry in the accepting cycle, then keeps busy high through the
// command state (modify and write back) and the response state (response build); its response
// beat comes in the first cycle with busy low. A tick sweeps the entry memory, reading one entry
// while writing back the one before, and keeps busy high through the sweep and response state.
// Reset is synchronous and active high; it clears the relay outputs, the memory valid bits
// and sets the maximum duration to one hour. The receiver cannot stall a response beat.
module relay_timer_cycle_controller_top #(
   parameter int RELAYS = rtcc_pkg::RELAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_mode,
   input  logic [2:0]  req_relay_index,
   input  logic [15:0] req_duration,
   input  logic [15:0] req_off_seconds,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic        rsp_relay_is_on,
   output logic        rsp_timer_running,
   output logic [15:0] rsp_remaining_seconds,
   output logic [7:0]  rsp_drive_n,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int AW = (RELAYS > 1) ? $clog2(RELAYS) : 1;
   localparam int CW = $clog2(RELAYS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_TICK = 4'b0010,
      ST_CMD  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   // Control registers.
   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic [RELAYS-1:0] relay_on_ff, relay_on_in;
   logic [15:0] max_dur_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   rtcc_pkg::mode_type mode_ff, mode_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] widx_ff, widx_in;
   logic [15:0] dur_ff, dur_in;
   logic [15:0] offs_ff, offs_in;
   logic        rpt_ff, rpt_in;
   logic        ok_ff, ok_in;
   rtcc_pkg::entry_type upd_ff, upd_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic        rsp_on_ff, rsp_on_in;
   logic        rsp_run_ff, rsp_run_in;
   logic [15:0] rsp_rem_ff, rsp_rem_in;
   logic [7:0]  rsp_drive_ff, rsp_drive_in;

   // Memory port.
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   rtcc_pkg::entry_type ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   rtcc_pkg::entry_type ram_rd_data;

   logic                accept;
   logic                in_range;
   logic                issue;
   rtcc_pkg::relay_type tick_cur, tick_nxt;
   rtcc_pkg::entry_type cmd_e;
   logic                cmd_on, cmd_ok;
   logic [15:0]         cl_dur, cl_offs;
   logic [7:0]          drive_n;

   rtcc_entry_ram #(
      .DEPTH (RELAYS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = (32'(req_relay_index) < RELAYS);
   assign issue    = (cnt_ff < CW'(RELAYS));

   // Active-low drive byte; positions without a relay stay de-energised.
   for (genvar i = 0; i < rtcc_pkg::DRIVE_BITS; i++) begin : g_drive
      if (i < RELAYS) begin : g_used
         assign drive_n[i] = ~relay_on_ff[i];
      end else begin : g_unused
         assign drive_n[i] = 1'b1;
      end
   end

   // One relay's tick update, applied to the entry read in the previous cycle.
   always_comb begin
      tick_cur.relay_on = relay_on_ff[widx_ff];
      tick_cur.entry    = ram_rd_data;
      tick_nxt          = rtcc_pkg::tick_step(tick_cur);
   end

   // Command update of the addressed entry.
   always_comb begin
      cl_dur  = rtcc_pkg::clamp_len(dur_ff, max_dur_ff);
      cl_offs = rtcc_pkg::clamp_len(offs_ff, max_dur_ff);
      cmd_e   = ram_rd_data;
      cmd_on  = relay_on_ff[idx_ff];
      cmd_ok  = 1'b1;
      unique case (mode_ff)
         rtcc_pkg::MODE_ON, rtcc_pkg::MODE_TIMED_ON: begin
            if (dur_ff != 16'd0) begin
               cmd_e.cycle_active = 1'b0;
               cmd_e.timer_active = 1'b1;
               cmd_e.timer_length = cl_dur;
               cmd_e.elapsed      = 16'd0;
               cmd_on             = 1'b1;
            end else if (mode_ff == rtcc_pkg::MODE_ON) begin
               cmd_e.cycle_active = 1'b0;
               cmd_e.timer_active = 1'b0;
               cmd_e.timer_length = 16'd0;
               cmd_e.elapsed      = 16'd0;
               cmd_on             = 1'b1;
            end else begin
               cmd_ok = 1'b0;
            end
         end
         rtcc_pkg::MODE_OFF, rtcc_pkg::MODE_TOGGLE: begin
            cmd_e.cycle_active = 1'b0;
            cmd_e.timer_active = 1'b0;
            cmd_e.timer_length = 16'd0;
            cmd_e.elapsed      = 16'd0;
            cmd_on             = (mode_ff == rtcc_pkg::MODE_TOGGLE) ? !relay_on_ff[idx_ff]
                                                                    : 1'b0;
         end
         rtcc_pkg::MODE_TIMED_OFF: begin
            // The off time is taken as given, without the clamp.
            if ((dur_ff == 16'd0) || !relay_on_ff[idx_ff]) begin
               cmd_ok = 1'b0;
            end else begin
               cmd_e.cycle_active = 1'b0;
               cmd_e.timer_active = 1'b1;
               cmd_e.timer_length = dur_ff;
               cmd_e.elapsed      = 16'd0;
            end
         end
         rtcc_pkg::MODE_CYCLE: begin
            if ((dur_ff == 16'd0) || (offs_ff == 16'd0)) begin
               cmd_ok = 1'b0;
            end else begin
               cmd_e.cycle_active = 1'b1;
               cmd_e.on_len       = cl_dur;
               cmd_e.off_len      = cl_offs;
               cmd_e.phase_is_on  = 1'b1;
               cmd_e.timer_active = 1'b1;
               cmd_e.timer_length = cl_dur;
               cmd_e.elapsed      = 16'd0;
               cmd_on             = 1'b1;
            end
         end
         rtcc_pkg::MODE_CYCLE_STOP: begin
            // Stopping a cycle leaves the relay where the current phase put it.
            if (ram_rd_data.cycle_active) begin
               cmd_e.cycle_active = 1'b0;
               cmd_e.timer_active = 1'b0;
               cmd_e.timer_length = 16'd0;
            end
         end
         rtcc_pkg::MODE_STATUS: begin
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      relay_on_in  = relay_on_ff;
      rsp_valid_in = 1'b0;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      widx_in      = widx_ff;
      dur_in       = dur_ff;
      offs_in      = offs_ff;
      rpt_in       = rpt_ff;
      ok_in        = ok_ff;
      upd_in       = upd_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_drive_in = rsp_drive_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = cmd_e;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(req_relay_index);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = rtcc_pkg::mode_type'(req_mode);
               dur_in  = req_duration;
               offs_in = req_off_seconds;
               idx_in  = in_range ? AW'(req_relay_index) : '0;
               if (req_mode == rtcc_pkg::MODE_TICK) begin
                  // The tick reports no relay and always succeeds.
                  rpt_in   = 1'b0;
                  ok_in    = 1'b1;
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_TICK;
               end else if (!in_range) begin
                  rpt_in   = 1'b0;
                  ok_in    = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  rpt_in    = 1'b1;
                  ram_rd_en = 1'b1;
                  state_in  = ST_CMD;
               end
            end
         end
         ST_TICK: begin
            // Read entry cnt while writing back entry cnt - 1.
            ram_rd_addr = cnt_ff[AW-1:0];
            ram_rd_en   = issue;
            if (pend_ff) begin
               ram_wr_en            = 1'b1;
               ram_wr_addr          = widx_ff;
               ram_wr_data          = tick_nxt.entry;
               relay_on_in[widx_ff] = tick_nxt.relay_on;
            end
            pend_in = issue;
            widx_in = cnt_ff[AW-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_CMD: begin
            ram_wr_en           = 1'b1;
            ram_wr_addr         = idx_ff;
            ram_wr_data         = cmd_e;
            relay_on_in[idx_ff] = cmd_on;
            upd_in              = cmd_e;
            ok_in               = cmd_ok;
            state_in            = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = ok_ff;
            rsp_on_in    = rpt_ff && relay_on_ff[idx_ff];
            rsp_run_in   = rpt_ff && (upd_ff.timer_active || upd_ff.cycle_active);
            rsp_rem_in   = rpt_ff ? rtcc_pkg::remaining(upd_ff) : 16'd0;
            rsp_drive_in = drive_n;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         relay_on_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         max_dur_ff   <= rtcc_pkg::MAX_DUR_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         relay_on_ff  <= relay_on_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_dur_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      widx_ff      <= widx_in;
      dur_ff       <= dur_in;
      offs_ff      <= offs_in;
      rpt_ff       <= rpt_in;
      ok_ff        <= ok_in;
      upd_ff       <= upd_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_on_ff    <= rsp_on_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ok                = rsp_ok_ff;
   assign rsp_relay_is_on       = rsp_on_ff;
   assign rsp_timer_running     = rsp_run_ff;
   assign rsp_remaining_seconds = rsp_rem_ff;
   assign rsp_drive_n           = rsp_drive_ff;

   // An accepted beat always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not raise busy");

   // A response beat comes only from the response state, in the cycle that follows it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_RESP) && (state_ff == ST_IDLE))
      else $error("response beat outside its slot");

   // The tick sweep never reads and writes the same entry in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr)))
      else $error("entry memory read and write collide");

   // A relay command writes back exactly one entry, the addressed one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMD) |-> ram_wr_en && (ram_wr_addr == idx_ff))
      else $error("command write-back missing or misdirected");

endmodule

// ----- rtl/core/rtcc_entry_ram.sv -----
module rtcc_entry_ram #(
   parameter int DEPTH = rtcc_pkg::RELAYS_DEF,
   parameter int AW    = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  rtcc_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output rtcc_pkg::entry_type rd_data
);

   rtcc_pkg::entry_type mem_ff [DEPTH];
   rtcc_pkg::entry_type rd_data_ff;
   logic [DEPTH-1:0]    vld_ff;
   logic                rd_vld_ff;

   // An entry that was never written since reset reads as an all-zero record.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // Modes 9 through 15 are not commands; the controller must reject them.
   localparam logic [3:0] MODE_UNUSED_FIRST = 4'd9;
   localparam logic [3:0] MODE_UNUSED_LAST  = 4'd15;

   localparam int RELAY_COUNT = rtcc_pkg::RELAYS_DEF;

   // A tick keeps busy high only for its sweep and response state and a command only for its
   // command and response states, so QUIET_LIMIT quiet cycles can only mean a hung handshake.
   localparam int QUIET_LIMIT = 600;

   // Cycles allowed after the last response before the verdict or a register
   // write. Every beat causes exactly one response, so this is only margin.
   localparam int IDLE_SETTLE = 6;
   localparam int FINAL_SETTLE = 20;

   localparam int SCRIPT_ROWS = 27;
   localparam int PHASES = 6;
   localparam int BEATS_PER_PHASE = 125;

   typedef struct packed {
      logic [3:0]  mode;
      logic [2:0]  relay;
      logic [15:0] dur;
      logic [15:0] off_s;
   } command_type;

   typedef struct packed {
      logic        ok;
      logic        is_on;
      logic        running;
      logic [15:0] remaining;
      logic [7:0]  drive_n;
   } status_type;

   // One line of the directed script: either a write of the maximum duration
   // register or a command beat, optionally with the response typed in.
   typedef struct packed {
      logic        is_cfg;
      logic [15:0] cfg_value;
      command_type cmd;
      logic        has_status;
      status_type  status;
   } script_row_type;

   // Our own view of one relay's timer and cycle bookkeeping.
   typedef struct {
      logic        on;
      logic        timer;
      logic [15:0] tlen;
      logic [15:0] elapsed;
      logic        cycling;
      logic        phase_on;
      logic [15:0] on_len;
      logic [15:0] off_len;
   } relay_shadow_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic        busy;
   logic [3:0]  req_mode        = 4'd0;
   logic [2:0]  req_relay_index = 3'd0;
   logic [15:0] req_duration    = 16'd0;
   logic [15:0] req_off_seconds = 16'd0;
   logic        rsp_valid;
   logic        rsp_ok;
   logic        rsp_relay_is_on;
   logic        rsp_timer_running;
   logic [15:0] rsp_remaining_seconds;
   logic [7:0]  rsp_drive_n;
   logic        csr_wr_en       = 1'b0;
   logic [15:0] csr_wr_data     = 16'd0;

   relay_shadow_type relay_view [RELAY_COUNT];
   logic [15:0]      shadow_max_dur;

   // Responses that the controller still owes, oldest first.
   status_type status_due_q [$];

   int mismatches   = 0;
   int quiet_cycles = 0;
   int burst_left   = 0;

   script_row_type script [SCRIPT_ROWS];

   relay_timer_cycle_controller_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_relay_index      (req_relay_index),
      .req_duration         (req_duration),
      .req_off_seconds      (req_off_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ok               (rsp_ok),
      .rsp_relay_is_on      (rsp_relay_is_on),
      .rsp_timer_running    (rsp_timer_running),
      .rsp_remaining_seconds(rsp_remaining_seconds),
      .rsp_drive_n          (rsp_drive_n),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Relay bookkeeping. These functions track what the controller should
   // hold for every relay, so each accepted beat can be turned into the
   // response it must produce.
   // ------------------------------------------------------------------

   // Timed and cycle lengths are clamped to the register; timed off is not.
   function automatic logic [15:0] clip_to_max(logic [15:0] secs);
      return (secs > shadow_max_dur) ? shadow_max_dur : secs;
   endfunction

   // Stopping a cycle also drops the timer that the cycle was driving. The
   // elapsed count and the phase are left as they were.
   function automatic void drop_cycle(int r);
      if (relay_view[r].cycling) begin
         relay_view[r].cycling = 1'b0;
         relay_view[r].timer   = 1'b0;
         relay_view[r].tlen    = 16'd0;
      end
   endfunction

   function automatic void set_level(int r, logic on);
      drop_cycle(r);
      relay_view[r].timer   = 1'b0;
      relay_view[r].tlen    = 16'd0;
      relay_view[r].elapsed = 16'd0;
      relay_view[r].on      = on;
   endfunction

   function automatic void arm_on_timer(int r, logic [15:0] secs);
      drop_cycle(r);
      relay_view[r].on      = 1'b1;
      relay_view[r].timer   = 1'b1;
      relay_view[r].tlen    = clip_to_max(secs);
      relay_view[r].elapsed = 16'd0;
   endfunction

   // One second passes for one relay. The elapsed count saturates. A plain
   // timer only switches the relay off if the relay is on; a cycle flips its
   // phase once the phase length is reached and restarts the count.
   function automatic void advance_second(int r);
      logic [15:0] len;
      if ((relay_view[r].timer || relay_view[r].cycling) &&
          (relay_view[r].elapsed != 16'hFFFF)) begin
         relay_view[r].elapsed = relay_view[r].elapsed + 16'd1;
      end
      if (!relay_view[r].cycling) begin
         if (relay_view[r].timer && relay_view[r].on &&
             (relay_view[r].elapsed >= relay_view[r].tlen)) begin
            relay_view[r].on    = 1'b0;
            relay_view[r].timer = 1'b0;
            relay_view[r].tlen  = 16'd0;
         end
      end else begin
         len = relay_view[r].phase_on ? relay_view[r].on_len : relay_view[r].off_len;
         relay_view[r].timer = 1'b1;
         relay_view[r].tlen  = len;
         if (relay_view[r].elapsed >= len) begin
            relay_view[r].phase_on = !relay_view[r].phase_on;
            relay_view[r].on       = relay_view[r].phase_on;
            relay_view[r].elapsed  = 16'd0;
            relay_view[r].tlen     = relay_view[r].phase_on ? relay_view[r].on_len
                                                            : relay_view[r].off_len;
         end
      end
   endfunction

   // Applies one beat to the relay bookkeeping and returns its response.
   function automatic status_type apply_command(command_type c);
      status_type  s;
      logic [15:0] len;
      int          r;
      logic        report;
      s      = '0;
      s.ok   = 1'b1;
      report = 1'b1;
      r      = c.relay;
      if (c.mode == rtcc_pkg::MODE_TICK) begin
         for (int i = 0; i < RELAY_COUNT; i++) advance_second(i);
         report = 1'b0;
      end else if (r >= RELAY_COUNT) begin
         s.ok   = 1'b0;
         report = 1'b0;
      end else begin
         case (c.mode)
            rtcc_pkg::MODE_ON: begin
               if (c.dur != 16'd0) arm_on_timer(r, c.dur);
               else set_level(r, 1'b1);
            end
            rtcc_pkg::MODE_OFF:    set_level(r, 1'b0);
            rtcc_pkg::MODE_TOGGLE: set_level(r, !relay_view[r].on);
            rtcc_pkg::MODE_TIMED_ON: begin
               if (c.dur == 16'd0) s.ok = 1'b0;
               else arm_on_timer(r, c.dur);
            end
            rtcc_pkg::MODE_TIMED_OFF: begin
               if (c.dur == 16'd0 || !relay_view[r].on) begin
                  s.ok = 1'b0;
               end else begin
                  drop_cycle(r);
                  relay_view[r].timer   = 1'b1;
                  relay_view[r].tlen    = c.dur;
                  relay_view[r].elapsed = 16'd0;
               end
            end
            rtcc_pkg::MODE_CYCLE: begin
               if (c.dur == 16'd0 || c.off_s == 16'd0) begin
                  s.ok = 1'b0;
               end else begin
                  drop_cycle(r);
                  relay_view[r].cycling  = 1'b1;
                  relay_view[r].on_len   = clip_to_max(c.dur);
                  relay_view[r].off_len  = clip_to_max(c.off_s);
                  relay_view[r].phase_on = 1'b1;
                  relay_view[r].on       = 1'b1;
                  relay_view[r].timer    = 1'b1;
                  relay_view[r].tlen     = relay_view[r].on_len;
                  relay_view[r].elapsed  = 16'd0;
               end
            end
            rtcc_pkg::MODE_CYCLE_STOP: drop_cycle(r);
            rtcc_pkg::MODE_STATUS: ;
            default: s.ok = 1'b0;
         endcase
      end
      if (report) begin
         s.is_on   = relay_view[r].on;
         s.running = relay_view[r].timer || relay_view[r].cycling;
         if (relay_view[r].cycling) begin
            len = relay_view[r].phase_on ? relay_view[r].on_len : relay_view[r].off_len;
         end else if (relay_view[r].timer) begin
            len = relay_view[r].tlen;
         end else begin
            len = 16'd0;
         end
         s.remaining = (len > relay_view[r].elapsed) ? len - relay_view[r].elapsed : 16'd0;
      end
      // The drive byte is active low; bits past the last relay stay high.
      s.drive_n = 8'hFF;
      for (int i = 0; i < RELAY_COUNT && i < rtcc_pkg::DRIVE_BITS; i++) begin
         if (relay_view[i].on) s.drive_n[i] = 1'b0;
      end
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   function automatic script_row_type cmd_row(logic [3:0] m, logic [2:0] r,
                                              logic [15:0] d, logic [15:0] o);
      script_row_type row;
      row     = '0;
      row.cmd = '{m, r, d, o};
      return row;
   endfunction

   function automatic script_row_type chk_row(logic [3:0] m, logic [2:0] r,
                                              logic [15:0] d, logic [15:0] o,
                                              status_type s);
      script_row_type row;
      row            = cmd_row(m, r, d, o);
      row.has_status = 1'b1;
      row.status     = s;
      return row;
   endfunction

   function automatic script_row_type cfg_row(logic [15:0] v);
      script_row_type row;
      row           = '0;
      row.is_cfg    = 1'b1;
      row.cfg_value = v;
      return row;
   endfunction

   // Second counts lean small so that timers expire and cycles flip often,
   // with zero for the rejection paths and full-width values now and then.
   function automatic logic [15:0] pick_seconds();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)  return 16'd0;
      if (roll < 80) return 16'($urandom_range(1, 8));
      if (roll < 92) return 16'($urandom_range(9, 300));
      return 16'($urandom());
   endfunction

   // Ticks dominate so that the timers and cycles that commands set up
   // actually run; unknown modes are sprinkled in as noise.
   function automatic command_type random_command();
      command_type c;
      int unsigned roll;
      roll    = $urandom_range(0, 99);
      c.relay = 3'($urandom());
      c.dur   = pick_seconds();
      c.off_s = pick_seconds();
      if (roll < 36) begin
         c.mode  = rtcc_pkg::MODE_TICK;
         c.dur   = 16'($urandom());
         c.off_s = 16'($urandom());
      end else if (roll < 44) begin
         c.mode = rtcc_pkg::MODE_ON;
         if ($urandom_range(0, 1) == 0) c.dur = 16'd0;
      end else if (roll < 50) c.mode = rtcc_pkg::MODE_OFF;
      else if (roll < 56) c.mode = rtcc_pkg::MODE_TOGGLE;
      else if (roll < 66) c.mode = rtcc_pkg::MODE_TIMED_ON;
      else if (roll < 75) c.mode = rtcc_pkg::MODE_TIMED_OFF;
      else if (roll < 86) c.mode = rtcc_pkg::MODE_CYCLE;
      else if (roll < 91) c.mode = rtcc_pkg::MODE_CYCLE_STOP;
      else if (roll < 97) c.mode = rtcc_pkg::MODE_STATUS;
      else c.mode = 4'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
      return c;
   endfunction

   // Presents one beat and holds it until the controller takes it. Start is
   // left high so that a back-to-back beat does not drop it for a cycle.
   task automatic send_command(command_type c, logic typed, status_type typed_status);
      status_type predicted;
      start           <= 1'b1;
      req_mode        <= c.mode;
      req_relay_index <= c.relay;
      req_duration    <= c.dur;
      req_off_seconds <= c.off_s;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_command(c);
      status_due_q.push_back(typed ? typed_status : predicted);
   endtask

   // The sender runs in bursts; between bursts it goes quiet for a random
   // number of cycles, and about one burst in four follows with no gap.
   task automatic pace();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // The register may only change while nothing is in flight.
   task automatic drain();
      start <= 1'b0;
      while (status_due_q.size() != 0 || busy) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_max_duration(logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      shadow_max_dur = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Response checker. A response beat lasts exactly one cycle and cannot
   // be held off, so it is sampled at every rising edge where the strobe is
   // up. Values read here are the ones from before the edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_valid) begin
         if (status_due_q.size() == 0) begin
            report_mismatch("response beat with nothing pending", 1, 0);
         end else begin
            want = status_due_q.pop_front();
            if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
            if (rsp_relay_is_on !== want.is_on) begin
               report_mismatch("relay_is_on", rsp_relay_is_on, want.is_on);
            end
            if (rsp_timer_running !== want.running) begin
               report_mismatch("timer_running", rsp_timer_running, want.running);
            end
            if (rsp_remaining_seconds !== want.remaining) begin
               report_mismatch("remaining_seconds", rsp_remaining_seconds, want.remaining);
            end
            if (rsp_drive_n !== want.drive_n) begin
               report_mismatch("drive_n", rsp_drive_n, want.drive_n);
            end
         end
      end
   end

   // Watchdog: any accepted beat on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, the directed script, then random phases, each
   // under its own maximum duration setting.
   // ------------------------------------------------------------------
   initial begin
      command_type c;
      for (int i = 0; i < RELAY_COUNT; i++) begin
         relay_view[i] = '{default: '0};
      end
      shadow_max_dur = rtcc_pkg::MAX_DUR_RST;

      // The directed script starts from reset with the one-hour clamp. Rows
      // with a typed response are ones whose answer is plain from the
      // command alone; the rest are checked by the bookkeeping above.
      script = '{
         // Status right after reset: everything off, drive byte all high.
         chk_row(rtcc_pkg::MODE_STATUS, 3'd0, 16'd0, 16'd0,
                 '{1'b1, 1'b0, 1'b0, 16'd0, 8'hFF}),
         // On with zero duration is a plain on with no timer.
         chk_row(rtcc_pkg::MODE_ON, 3'd0, 16'd0, 16'd0,
                 '{1'b1, 1'b1, 1'b0, 16'd0, 8'hFE}),
         // The largest timed on is clamped to the one-hour register value.
         chk_row(rtcc_pkg::MODE_TIMED_ON, 3'd7, 16'hFFFF, 16'hFFFF,
                 '{1'b1, 1'b1, 1'b1, 16'd3600, 8'h7E}),
         // Timed on with no duration is refused.
         chk_row(rtcc_pkg::MODE_TIMED_ON, 3'd1, 16'd0, 16'd0,
                 '{1'b0, 1'b0, 1'b0, 16'd0, 8'h7E}),
         // Timed off on a relay that is off is refused.
         chk_row(rtcc_pkg::MODE_TIMED_OFF, 3'd2, 16'd5, 16'd0,
                 '{1'b0, 1'b0, 1'b0, 16'd0, 8'h7E}),
         // A cycle needs both phases to be at least one second.
         chk_row(rtcc_pkg::MODE_CYCLE, 3'd3, 16'd2, 16'd0,
                 '{1'b0, 1'b0, 1'b0, 16'd0, 8'h7E}),
         chk_row(rtcc_pkg::MODE_CYCLE, 3'd3, 16'd0, 16'd3,
                 '{1'b0, 1'b0, 1'b0, 16'd0, 8'h7E}),
         chk_row(rtcc_pkg::MODE_CYCLE, 3'd3, 16'd2, 16'd1,
                 '{1'b1, 1'b1, 1'b1, 16'd2, 8'h76}),
         // A tick reports nothing about a relay, only the drive byte.
         chk_row(rtcc_pkg::MODE_TICK, 3'd5, 16'hFFFF, 16'hFFFF,
                 '{1'b1, 1'b0, 1'b0, 16'd0, 8'h76}),
         // Two more seconds: the cycle ends its on phase, then its off phase.
         cmd_row(rtcc_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0),
         cmd_row(rtcc_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0),
         cmd_row(rtcc_pkg::MODE_TOGGLE, 3'd0, 16'd0, 16'd0),
         cmd_row(rtcc_pkg::MODE_ON, 3'd4, 16'hFFFF, 16'd0),
         // Timed off is not clamped, so the full count stays.
         cmd_row(rtcc_pkg::MODE_TIMED_OFF, 3'd4, 16'hFFFF, 16'd0),
         cmd_row(rtcc_pkg::MODE_TIMED_OFF, 3'd5, 16'hFFFF, 16'd0),
         cmd_row(rtcc_pkg::MODE_CYCLE_STOP, 3'd3, 16'd0, 16'd0),
         cmd_row(rtcc_pkg::MODE_STATUS, 3'd3, 16'd0, 16'd0),
         // An unused mode is refused but still reports the addressed relay.
         cmd_row(MODE_UNUSED_LAST, 3'd7, 16'hFFFF, 16'hFFFF),
         cmd_row(rtcc_pkg::MODE_OFF, 3'd7, 16'd0, 16'd0),
         // With a zero clamp a cycle flips every second and a timed on ends
         // at the very next tick.
         cfg_row(16'd0),
         cmd_row(rtcc_pkg::MODE_CYCLE, 3'd6, 16'd9, 16'd9),
         cmd_row(rtcc_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0),
         cmd_row(rtcc_pkg::MODE_TIMED_ON, 3'd5, 16'd100, 16'd0),
         cmd_row(rtcc_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0),
         // The widest clamp lets the longest cycle through untouched.
         cfg_row(16'hFFFF),
         cmd_row(rtcc_pkg::MODE_CYCLE, 3'd2, 16'hFFFF, 16'hFFFF),
         cmd_row(rtcc_pkg::MODE_CYCLE_STOP, 3'd6, 16'd0, 16'd0)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         if (script[i].is_cfg) begin
            drain();
            write_max_duration(script[i].cfg_value);
         end else begin
            send_command(script[i].cmd, script[i].has_status, script[i].status);
            pace();
         end
      end

      // Random phases. Each one starts from an idle controller with its own
      // clamp: small, one second, the widest, zero, any value,
      // and back to the reset value.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0:       write_max_duration(16'($urandom_range(2, 12)));
            1:       write_max_duration(16'd1);
            2:       write_max_duration(16'hFFFF);
            3:       write_max_duration(16'd0);
            4:       write_max_duration(16'($urandom()));
            default: write_max_duration(rtcc_pkg::MAX_DUR_RST);
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            c = random_command();
            send_command(c, 1'b0, '0);
            pace();
         end
      end

      // Let the last responses come back, then give any stray beat a chance
      // to show up before the verdict. The watchdog bounds this wait.
      start <= 1'b0;
      while (status_due_q.size() != 0) @(posedge clock);
      repeat (FINAL_SETTLE) @(posedge clock);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
